@@ hdl/indexed_min_heap_unit_assert.svh @@
// ============================================================================
// indexed_min_heap_unit_assert.svh
// Assertion macros for the indexed min-heap unit. Empty in synthesis.
// ============================================================================
`ifndef INDEXED_MIN_HEAP_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IMH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imh: same-cycle check failed");
// next-cycle implication
`define IMH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imh: next-cycle check failed");
`else
`define IMH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IMH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/imh_pkg.sv @@
// ============================================================================
// imh_pkg
// Shared types and constants of the indexed min-heap unit.
// ============================================================================
package imh_pkg;

    localparam int IMH_CAPACITY = 1024;
    localparam int IMH_KEY_BITS = 32;
    localparam int HANDLE_W     = 10;
    localparam int NUM_HANDLES  = 1024;
    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 11;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_PRESENT = 2'd3
    } t_status;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    // item handed to the sequencer
    typedef struct packed {
        logic                action;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } t_req;

    // result item built by the sequencer
    typedef struct packed {
        t_status             status;
        logic [COUNT_W-1:0]  entry_count;
        logic                min_valid;
        logic [HANDLE_W-1:0] min_handle;
        logic [KEY_W-1:0]    min_key;
    } t_rsp;

    // top level to sequencer
    typedef struct packed {
        logic start;
        logic take;
    } t_core_ctl;

    // sequencer to top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_core_sts;

endpackage

@@ hdl/imh_in_if.sv @@
// ============================================================================
// imh_in_if
// Request channel: valid/ready with one heap operation per item.
// ============================================================================
interface imh_in_if import imh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;

    modport source (output valid, output action, output handle, output key, input ready);
    modport sink   (input valid, input action, input handle, input key, output ready);
endinterface

@@ hdl/imh_out_if.sv @@
// ============================================================================
// imh_out_if
// Result channel: valid/ready with status, count and current minimum.
// ============================================================================
interface imh_out_if import imh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  entry_count;
    logic                min_valid;
    logic [HANDLE_W-1:0] min_handle;
    logic [KEY_W-1:0]    min_key;

    modport source (output valid, output status, output entry_count, output min_valid,
                    output min_handle, output min_key, input ready);
    modport sink   (input valid, input status, input entry_count, input min_valid,
                    input min_handle, input min_key, output ready);
endinterface

@@ hdl/imh_ram.sv @@
// ============================================================================
// imh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module imh_ram import imh_pkg::*; #(
    parameter int W = KEY_W,
    parameter int D = NUM_HANDLES
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/imh_core.sv @@
// ============================================================================
// imh_core
// Heap sequencer: clears the presence table, then runs insert and remove
// with a hole-based sift over one heap RAM read port and one write port.
// ============================================================================
module imh_core import imh_pkg::*; #(
    parameter int CAPACITY = IMH_CAPACITY,
    parameter int KEY_BITS = IMH_KEY_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    input  t_req      i_req,
    output t_core_sts o_sts,
    output t_rsp      o_rsp
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SK = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int IW = PW + 2;
    localparam int EW = HANDLE_W + SK;

    typedef struct packed {
        logic [HANDLE_W-1:0] h;
        logic [SK-1:0]       k;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_RMLD, S_SD_RDL, S_SD_RDR, S_SD_CMP,
        S_SU_RD, S_SU_CMP, S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [PW-1:0]       r_p, n_p;
    t_entry              r_cur, n_cur;
    t_entry              r_left, n_left;
    logic                r_has_r, n_has_r;
    t_status             r_status, n_status;
    logic                r_action, n_action;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    t_entry              r_top, n_top;
    logic [HANDLE_W-1:0] r_clr_idx, n_clr_idx;

    // RAM ports
    logic                heap_we;
    logic [PW-1:0]       heap_waddr, heap_raddr;
    t_entry              heap_wdata, heap_rdata;
    logic [EW-1:0]       heap_rdata_raw;
    logic                pos_we;
    logic [HANDLE_W-1:0] pos_waddr;
    logic [PW-1:0]       pos_wdata, pos_rdata;
    logic                pres_we;
    logic [HANDLE_W-1:0] pres_waddr;
    logic [0:0]          pres_wdata, pres_rdata;

    // index arithmetic
    logic [IW-1:0]       left_idx, right_idx, count_ext;
    logic                has_left, has_right;
    logic [PW-1:0]       parent_idx, last_idx;
    logic                right_lt;
    t_entry              child;
    logic [PW-1:0]       child_idx;

    imh_ram #(.W(EW), .D(CAPACITY)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata_raw)
    );
    assign heap_rdata = heap_rdata_raw;

    imh_ram #(.W(PW), .D(NUM_HANDLES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (i_req.handle),
        .o_rdata (pos_rdata)
    );

    imh_ram #(.W(1), .D(NUM_HANDLES)) u_pres_ram (
        .i_clk   (i_clk),
        .i_we    (pres_we),
        .i_waddr (pres_waddr),
        .i_wdata (pres_wdata),
        .i_raddr (i_req.handle),
        .o_rdata (pres_rdata)
    );

    // tree navigation
    assign count_ext  = IW'(r_count);
    assign left_idx   = (IW'(r_p) << 1) + IW'(1);
    assign right_idx  = left_idx + IW'(1);
    assign has_left   = left_idx < count_ext;
    assign has_right  = right_idx < count_ext;
    assign parent_idx = (r_p - PW'(1)) >> 1;
    assign last_idx   = PW'(r_count - CW'(1));

    // smaller child, left on ties
    assign right_lt  = r_has_r && (heap_rdata.k < r_left.k);
    assign child     = right_lt ? heap_rdata : r_left;
    assign child_idx = right_lt ? PW'(right_idx) : PW'(left_idx);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_p        = r_p;
        n_cur      = r_cur;
        n_left     = r_left;
        n_has_r    = r_has_r;
        n_status   = r_status;
        n_action   = r_action;
        n_handle   = r_handle;
        n_top      = r_top;
        n_clr_idx  = r_clr_idx;
        heap_we    = 1'b0;
        heap_waddr = r_p;
        heap_wdata = r_cur;
        heap_raddr = last_idx;
        pos_we     = 1'b0;
        pos_waddr  = r_cur.h;
        pos_wdata  = r_p;
        pres_we    = 1'b0;
        pres_waddr = r_handle;
        pres_wdata = 1'b0;

        unique case (r_state)
            // sweep the presence table after reset
            S_CLR: begin
                pres_we    = 1'b1;
                pres_waddr = r_clr_idx;
                n_clr_idx  = r_clr_idx + HANDLE_W'(1);
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_action = i_req.action;
                    n_handle = i_req.handle;
                    n_cur    = '{h: i_req.handle, k: i_req.key[SK-1:0]};
                    n_state  = S_DEC;
                end
            end
            // presence and position are back; heap[last] is being read
            S_DEC: begin
                n_status = ST_OK;
                if (r_action == ACT_INSERT) begin
                    priority if (pres_rdata[0]) begin
                        n_status = ST_PRESENT;
                        n_state  = S_DONE;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        pres_we    = 1'b1;
                        pres_wdata = 1'b1;
                        n_p        = PW'(r_count);
                        n_count    = r_count + CW'(1);
                        n_state    = S_SU_RD;
                    end
                end else begin
                    priority if (!pres_rdata[0]) begin
                        n_status = ST_ABSENT;
                        n_state  = S_DONE;
                    end else if (CW'(pos_rdata) >= r_count) begin
                        n_status = ST_ABSENT;
                        n_state  = S_DONE;
                    end else begin
                        pres_we = 1'b1;
                        n_count = r_count - CW'(1);
                        n_p     = pos_rdata;
                        if (pos_rdata == last_idx) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_RMLD;
                        end
                    end
                end
            end
            // last entry becomes the moving entry
            S_RMLD: begin
                n_cur   = heap_rdata;
                n_state = S_SD_RDL;
            end
            S_SD_RDL: begin
                if (has_left) begin
                    heap_raddr = PW'(left_idx);
                    n_state    = S_SD_RDR;
                end else begin
                    n_state = S_SU_RD;
                end
            end
            S_SD_RDR: begin
                n_left     = heap_rdata;
                n_has_r    = has_right;
                heap_raddr = PW'(right_idx);
                n_state    = S_SD_CMP;
            end
            // child moves up into the hole when strictly smaller
            S_SD_CMP: begin
                if (child.k < r_cur.k) begin
                    heap_we    = 1'b1;
                    heap_wdata = child;
                    pos_we     = 1'b1;
                    pos_waddr  = child.h;
                    n_p        = child_idx;
                    n_state    = S_SD_RDL;
                end else begin
                    n_state = S_SU_RD;
                end
            end
            S_SU_RD: begin
                if (r_p == '0) begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    heap_raddr = parent_idx;
                    n_state    = S_SU_CMP;
                end
            end
            // parent moves down into the hole when strictly larger
            S_SU_CMP: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (r_cur.k < heap_rdata.k) begin
                    heap_wdata = heap_rdata;
                    pos_waddr  = heap_rdata.h;
                    n_p        = parent_idx;
                    n_state    = S_SU_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // shadow copy of the heap top
        if (heap_we && heap_waddr == '0) begin
            n_top = heap_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_count   <= '0;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_clr_idx <= n_clr_idx;
        end
        r_p      <= n_p;
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_has_r  <= n_has_r;
        r_status <= n_status;
        r_action <= n_action;
        r_handle <= n_handle;
        r_top    <= n_top;
    end

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE);

    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = COUNT_W'(r_count);
    assign o_rsp.min_valid   = (r_count != '0);
    assign o_rsp.min_handle  = (r_count != '0) ? r_top.h : '0;
    assign o_rsp.min_key     = (r_count != '0) ? KEY_W'(r_top.k) : '0;

endmodule

@@ hdl/indexed_min_heap_unit.sv @@
// ============================================================================
// indexed_min_heap_unit
// Indexed binary min-heap of (handle, key) entries with removal by handle.
// ============================================================================
// Request channel i_req_ch carries action (insert or remove), handle and key;
// the result channel o_rsp_ch returns one item per request: status, entry
// count and the current minimum (handle and key, zero when empty).
// One request is in flight at a time; ready is high only while the sequencer
// is idle. An insert takes the next free slot and sifts the new entry up; a
// remove moves the last entry into the freed slot and sifts it down, then up.
// Each sift-up level reads the parent from the heap RAM and then compares and
// moves; each sift-down level reads the left and the right child, then
// compares and moves. A sift covers at most log2(CAPACITY) levels. Rejected
// requests (absent, full, present) and last-slot removes skip the sift.
// After reset the handle presence table (NUM_HANDLES entries, 1024) is
// cleared with ready low; the heap then starts empty.
// The result sits in an output register, so a new request is accepted while
// a result waits; if the receiver stalls, the next result holds inside the
// sequencer until the output register frees up.
// ============================================================================
`include "indexed_min_heap_unit_assert.svh"

module indexed_min_heap_unit import imh_pkg::*; #(
    parameter int CAPACITY = IMH_CAPACITY,
    parameter int KEY_BITS = IMH_KEY_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    imh_in_if.sink    i_req_ch,
    imh_out_if.source o_rsp_ch
);

    t_core_ctl core_ctl;
    t_core_sts core_sts;
    t_req      core_req;
    t_rsp      core_rsp;
    logic      r_out_valid;
    t_rsp      r_out;

    // request side
    assign core_req.action = i_req_ch.action;
    assign core_req.handle = i_req_ch.handle;
    assign core_req.key    = i_req_ch.key;
    assign i_req_ch.ready  = core_sts.idle;
    assign core_ctl.start  = i_req_ch.valid && core_sts.idle;
    assign core_ctl.take   = core_sts.done && (!r_out_valid || o_rsp_ch.ready);

    imh_core #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_req   (core_req),
        .o_sts   (core_sts),
        .o_rsp   (core_rsp)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_ctl.take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp_ch.ready) begin
            r_out_valid <= 1'b0;
        end
        if (core_ctl.take) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp_ch.valid       = r_out_valid;
    assign o_rsp_ch.status      = r_out.status;
    assign o_rsp_ch.entry_count = r_out.entry_count;
    assign o_rsp_ch.min_valid   = r_out.min_valid;
    assign o_rsp_ch.min_handle  = r_out.min_handle;
    assign o_rsp_ch.min_key     = r_out.min_key;

    // checks
    `IMH_ASSERT_IMP(a_ready_not_done, i_clk, i_rst_n, i_req_ch.ready, !core_sts.done)
    `IMH_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_req_ch.valid && i_req_ch.ready, !i_req_ch.ready)
    `IMH_ASSERT_IMP(a_full_count, i_clk, i_rst_n, r_out_valid && r_out.status == ST_FULL, r_out.entry_count == COUNT_W'(CAPACITY))

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed min-heap unit.
// ----------------------------------------------------------------------------
// Requests are sent in random bursts over the request channel. A local copy of
// the heap (keys, handles, slot table and presence bits) tracks every accepted
// item and queues the status, count and minimum that the unit must return.
// A checker pops that queue on each accepted result and compares all fields.
// The result side stalls on changing patterns. One phase holds it off long
// enough to back the unit up into its input. The tests cover the following:
// corner keys and handles, filling the heap to capacity and draining part of
// it, and a random mix of inserts and removes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imh_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // idle cycles, covers table clear
    localparam int LONG_HOLD      = 400;   // result-side hold-off, in cycles
    localparam int RANDOM_ITEMS   = 340;
    localparam int DRAIN_ITEMS    = 64;
    localparam int MAX_SHOWN      = 10;

    logic i_clk;
    logic i_rst_n;

    imh_in_if  req_ch ();
    imh_out_if rsp_ch ();

    indexed_min_heap_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req_ch (req_ch),
        .o_rsp_ch (rsp_ch)
    );

    // shadow heap
    logic [KEY_W-1:0]    heap_key       [IMH_CAPACITY];
    logic [HANDLE_W-1:0] heap_hdl       [IMH_CAPACITY];
    int unsigned         slot_of_handle [NUM_HANDLES];
    bit                  handle_live    [NUM_HANDLES];
    int unsigned         heap_size = 0;

    t_rsp heap_results_due [$];
    int   mismatches     = 0;
    int   idle_cycles    = 0;
    int   burst_left     = 0;
    bit   long_hold_req  = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // heap prediction
    // ------------------------------------------------------------------------
    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [KEY_W-1:0]    k;
        logic [HANDLE_W-1:0] h;
        k = heap_key[a];
        h = heap_hdl[a];
        heap_key[a] = heap_key[b];
        heap_hdl[a] = heap_hdl[b];
        heap_key[b] = k;
        heap_hdl[b] = h;
        slot_of_handle[heap_hdl[a]] = a;
        slot_of_handle[heap_hdl[b]] = b;
    endfunction

    // move up while the parent is strictly larger
    function automatic void climb(int unsigned p);
        int unsigned up;
        while (p > 0 && p < heap_size) begin
            up = (p - 1) / 2;
            if (heap_key[p] < heap_key[up]) begin
                swap_slots(p, up);
                p = up;
            end else begin
                break;
            end
        end
    endfunction

    // move down to the smaller child (left on ties) while it is strictly smaller
    function automatic int unsigned descend(int unsigned p);
        int unsigned l;
        int unsigned c;
        forever begin
            l = 2 * p + 1;
            if (l >= heap_size) break;
            c = l;
            if (l + 1 < heap_size && heap_key[l + 1] < heap_key[l]) c = l + 1;
            if (heap_key[c] < heap_key[p]) begin
                swap_slots(p, c);
                p = c;
            end else begin
                break;
            end
        end
        return p;
    endfunction

    function automatic t_rsp apply_heap_op(t_action act, logic [HANDLE_W-1:0] hdl,
                                           logic [KEY_W-1:0] k);
        t_rsp        r;
        int unsigned p;
        int unsigned last;
        r = '0;
        r.status = ST_OK;
        if (act == ACT_INSERT) begin
            // presence is checked before capacity
            if (handle_live[hdl]) begin
                r.status = ST_PRESENT;
            end else if (heap_size >= IMH_CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                p = heap_size;
                heap_key[p] = k;
                heap_hdl[p] = hdl;
                slot_of_handle[hdl] = p;
                handle_live[hdl] = 1'b1;
                heap_size++;
                climb(p);
            end
        end else begin
            p = slot_of_handle[hdl];
            if (!handle_live[hdl] || p >= heap_size) begin
                r.status = ST_ABSENT;
            end else begin
                last = heap_size - 1;
                handle_live[hdl] = 1'b0;
                heap_size = last;
                // last slot is simply dropped
                if (p != last) begin
                    heap_key[p] = heap_key[last];
                    heap_hdl[p] = heap_hdl[last];
                    slot_of_handle[heap_hdl[p]] = p;
                    p = descend(p);
                    climb(p);
                end
            end
        end
        r.entry_count = COUNT_W'(heap_size);
        if (heap_size > 0) begin
            r.min_valid  = 1'b1;
            r.min_handle = heap_hdl[0];
            r.min_key    = heap_key[0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // random handle in the wanted state, probing upward from a random start
    function automatic logic [HANDLE_W-1:0] pick_handle(bit want_live);
        int unsigned start;
        int unsigned h;
        start = $urandom_range(0, NUM_HANDLES - 1);
        for (int i = 0; i < NUM_HANDLES; i++) begin
            h = (start + i) % NUM_HANDLES;
            if (handle_live[h] == want_live) return HANDLE_W'(h);
        end
        return HANDLE_W'(start);
    endfunction

    // mix of full-range, tie-prone, top-end and whole-number Q2.30 keys
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return KEY_W'($urandom_range(0, 7));
            1:       return 32'hFFFF_FFFF - KEY_W'($urandom_range(0, 3));
            2:       return {2'($urandom_range(0, 3)), 30'h0};
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // send one item in bursts with random gaps, then predict its result
    task automatic send_heap_op(t_action act, logic [HANDLE_W-1:0] hdl,
                                logic [KEY_W-1:0] k);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 15);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.handle <= hdl;
        req_ch.key    <= k;
        do @(posedge i_clk); while (!req_ch.ready);
        heap_results_due = {heap_results_due, apply_heap_op(act, hdl, k)};
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_heap_op(ACT_REMOVE, 10'd5, 32'h0);            // remove on empty heap
        send_heap_op(ACT_INSERT, 10'd0, 32'hFFFF_FFFF);
        send_heap_op(ACT_INSERT, 10'd1023, 32'h0);         // new minimum
        send_heap_op(ACT_INSERT, 10'd0, 32'h7);            // duplicate handle
        send_heap_op(ACT_INSERT, 10'd512, 32'h0);          // tie with the top
        send_heap_op(ACT_INSERT, 10'd341, 32'h4000_0000);
        send_heap_op(ACT_INSERT, 10'd682, 32'hC000_0000);
        send_heap_op(ACT_INSERT, 10'd100, 32'h1234_5678);
        send_heap_op(ACT_INSERT, 10'd101, 32'h1234_5678);
        send_heap_op(ACT_INSERT, 10'd102, 32'h1234_5678);
        send_heap_op(ACT_REMOVE, 10'd101, 32'hFFFF_FFFF);  // leaf, not last slot; equal keys
        send_heap_op(ACT_REMOVE, 10'd1023, 32'h0);         // top
        send_heap_op(ACT_REMOVE, 10'd777, 32'h0);          // absent handle
        send_heap_op(ACT_REMOVE, heap_hdl[heap_size - 1], 32'h0);  // last slot
        send_heap_op(ACT_REMOVE, 10'd0, 32'h0);
        send_heap_op(ACT_INSERT, 10'd1023, 32'hFFFF_FFFF); // handle reused
        send_heap_op(ACT_INSERT, 10'd0, 32'h1);
        // drain from the top down to empty
        while (heap_size > 0) send_heap_op(ACT_REMOVE, heap_hdl[0], 32'hA5A5_A5A5);
    endtask

    // result side held off while inserts keep coming
    task automatic test_backpressure();
        burst_left = 24;
        long_hold_req = 1'b1;
        for (int i = 0; i < 16; i++) send_heap_op(ACT_INSERT, pick_handle(1'b0), pick_key());
    endtask

    // every handle in the heap, then duplicates at capacity, then a partial drain
    task automatic test_fill_and_drain();
        while (heap_size < IMH_CAPACITY)
            send_heap_op(ACT_INSERT, pick_handle(1'b0), pick_key());
        for (int i = 0; i < 3; i++)
            send_heap_op(ACT_INSERT, pick_handle(1'b1), pick_key());
        while (heap_size > IMH_CAPACITY - DRAIN_ITEMS) begin
            if ($urandom_range(0, 19) == 0)
                send_heap_op(ACT_INSERT, pick_handle(1'b1), pick_key());
            send_heap_op(ACT_REMOVE, pick_handle(1'b1), KEY_W'($urandom));
        end
    endtask

    // insert-heavy first half, remove-heavy second half, some rejected items
    task automatic test_random_mix();
        int insert_pct;
        int r;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            insert_pct = (n < RANDOM_ITEMS / 2) ? 65 : 35;
            r = $urandom_range(0, 99);
            if (r < 5 && heap_size < IMH_CAPACITY)
                send_heap_op(ACT_REMOVE, pick_handle(1'b0), KEY_W'($urandom));
            else if (r < 10 && heap_size > 0)
                send_heap_op(ACT_INSERT, pick_handle(1'b1), pick_key());
            else if (heap_size == 0 ||
                     (heap_size < IMH_CAPACITY && $urandom_range(0, 99) < insert_pct))
                send_heap_op(ACT_INSERT, pick_handle(1'b0), pick_key());
            else
                send_heap_op(ACT_REMOVE, pick_handle(1'b1), KEY_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.action <= ACT_INSERT;
        req_ch.handle <= '0;
        req_ch.key    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_fill_and_drain();
        test_random_mix();

        req_ch.valid <= 1'b0;
        while (heap_results_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // result-side ready: changing stall patterns plus one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int          mode;
        int          mode_left;
        int          hold_left;
        logic [15:0] stall_mask;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        stall_mask = '1;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode       = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 200);
                    stall_mask = 16'($urandom);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: begin
                        stall_mask = {stall_mask[14:0], stall_mask[15]};
                        rsp_ch.ready <= stall_mask[0];
                    end
                    default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (heap_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%t: result with none expected: st=%0d cnt=%0d mv=%0b h=%0d k=%h",
                             $realtime, rsp_ch.status, rsp_ch.entry_count, rsp_ch.min_valid,
                             rsp_ch.min_handle, rsp_ch.min_key);
            end else begin
                exp_rsp = heap_results_due.pop_front();
                if (rsp_ch.status !== exp_rsp.status ||
                    rsp_ch.entry_count !== exp_rsp.entry_count ||
                    rsp_ch.min_valid !== exp_rsp.min_valid ||
                    rsp_ch.min_handle !== exp_rsp.min_handle ||
                    rsp_ch.min_key !== exp_rsp.min_key) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"%t: mismatch exp st=%0d cnt=%0d mv=%0b h=%0d k=%h",
                                  " got st=%0d cnt=%0d mv=%0b h=%0d k=%h"},
                                 $realtime, exp_rsp.status, exp_rsp.entry_count,
                                 exp_rsp.min_valid, exp_rsp.min_handle, exp_rsp.min_key,
                                 rsp_ch.status, rsp_ch.entry_count, rsp_ch.min_valid,
                                 rsp_ch.min_handle, rsp_ch.min_key);
                end
            end
        end
    end

    // watchdog: consecutive cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%t: watchdog, nothing accepted for %0d cycles", $realtime, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/imh_pkg.sv
hdl/imh_in_if.sv
hdl/imh_out_if.sv
hdl/imh_ram.sv
hdl/imh_core.sv
hdl/indexed_min_heap_unit.sv
test/tb.sv
